### rtl/core/mbuv_pkg.sv
`default_nettype none
package mbuv_pkg;

   // default sizes
   localparam int MAX_TRIANGLES_DEF = 1024;
   localparam int MAX_POINTS_DEF    = 2048;
   localparam int FRAC_BITS_DEF     = 16;

   // weight range after saturation
   localparam logic signed [31:0] WEIGHT_MAX = 32'sd1073741823;

   // operation codes
   localparam logic [1:0] OP_IMG_POINT = 2'd0;
   localparam logic [1:0] OP_TEX_POINT = 2'd1;
   localparam logic [1:0] OP_TRIANGLE  = 2'd2;
   localparam logic [1:0] OP_QUERY     = 2'd3;

   typedef logic signed [31:0] weight_type;

   // divider result handed back to the sequencer
   typedef struct packed {
      logic       done;
      weight_type quo;
   } div_res_type;

endpackage
`default_nettype wire

### rtl/core/mbuv_ram.sv
`default_nettype none
module mbuv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### rtl/core/mbuv_div.sv
`default_nettype none
module mbuv_div
   import mbuv_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] num,
   input  wire logic signed [63:0] den,
   output div_res_type             res
);

   localparam int NW    = 94;
   localparam int STEPS = 30;
   localparam int CW    = $clog2(STEPS);

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_RUN  = 3'b010,
      D_FIN  = 3'b100
   } dstate_type;

   dstate_type        state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [63:0]       d_ff, d_in;
   logic [63:0]       rem_ff, rem_in;
   logic [STEPS-1:0]  nlow_ff, nlow_in;
   logic [STEPS-1:0]  q_ff, q_in;
   logic              done_ff, done_in;
   weight_type        quo_ff, quo_in;

   logic [63:0]       nmag, dmag;
   logic [NW-1:0]     nsh, dsh;
   logic              ovf, start_neg;
   logic [63:0]       trial;
   logic [30:0]       qadj;
   logic [30:0]       qsat;

   // operand magnitudes and the overflow test
   assign nmag      = num[63] ? (64'd0 - num) : num;
   assign dmag      = den[63] ? (64'd0 - den) : den;
   assign start_neg = num[63] ^ den[63];
   assign nsh       = {30'd0, nmag} << FRAC_BITS;
   assign dsh       = {dmag, 30'd0};
   assign ovf       = (nsh >= dsh);
   assign trial     = {rem_ff[62:0], nlow_ff[STEPS-1]};

   // final rounding toward minus infinity and saturation
   assign qadj = {1'b0, q_ff} + {30'd0, (neg_ff && (rem_ff != 64'd0))};
   assign qsat = (qadj > WEIGHT_MAX[30:0]) ? WEIGHT_MAX[30:0] : qadj;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      nlow_in  = nlow_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               neg_in  = start_neg;
               d_in    = dmag;
               rem_in  = nsh[STEPS+63:STEPS];
               nlow_in = nsh[STEPS-1:0];
               q_in    = '0;
               cnt_in  = '0;
               if (ovf) begin
                  quo_in  = start_neg ? -WEIGHT_MAX : WEIGHT_MAX;
                  done_in = 1'b1;
               end else begin
                  state_in = D_RUN;
               end
            end
         end
         D_RUN: begin
            // one restoring step per cycle
            if (trial >= d_ff) begin
               rem_in = trial - d_ff;
               q_in   = {q_ff[STEPS-2:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in   = {q_ff[STEPS-2:0], 1'b0};
            end
            nlow_in = {nlow_ff[STEPS-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CW'(STEPS - 1)) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            quo_in   = neg_ff ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      nlow_ff <= nlow_in;
      q_ff    <= q_in;
      quo_ff  <= quo_in;
   end

   assign res.done = done_ff;
   assign res.quo  = quo_ff;

endmodule
`default_nettype wire

### rtl/core/mesh_barycentric_uv_lookup_core.sv
`default_nettype none
// channel   direction  handshake              contents
// req_      in         req_valid / req_stall  op, slot, point, corner and texture indices
// rsp_      out        rsp_valid / rsp_stall  u, v, inside flag, triangle index
// csr_      in         csr_valid / csr_ready  triangle count
//
// writes are taken while the sequencer is idle; a query walks the triangles one by one, skipping
// degenerate ones, with the shared 30-step divider run twice per other triangle and cut short
// when a division saturates; interpolation of the texture point then follows
// reset clears the sequencer and the triangle count, the stores hold no reset value
// a finished result waits in the output register while rsp_stall is high; the next
// query is taken meanwhile and only its own result waits for that register to free
module mesh_barycentric_uv_lookup_core
   import mbuv_pkg::*;
#(
   parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
   parameter int MAX_POINTS    = MAX_POINTS_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_op,
   input  wire logic [10:0]        req_slot,
   input  wire logic signed [31:0] req_x_value,
   input  wire logic signed [31:0] req_y_value,
   input  wire logic [10:0]        req_corner_a,
   input  wire logic [10:0]        req_corner_b,
   input  wire logic [10:0]        req_corner_c,
   input  wire logic [10:0]        req_tex_a,
   input  wire logic [10:0]        req_tex_b,
   input  wire logic [10:0]        req_tex_c,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_u_coord,
   output logic signed [31:0]      rsp_v_coord,
   output logic                    rsp_inside_res,
   output logic [9:0]              rsp_triangle_found,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [10:0]        csr_wdata
);

   localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int TCW = $clog2(MAX_TRIANGLES + 1);

   localparam logic signed [31:0] ONE_Q  = 32'(1 << FRAC_BITS);
   localparam logic signed [31:0] HALF_Q = 32'(1 << (FRAC_BITS - 1));
   localparam logic signed [31:0] INIT_W = 32'(10 * (1 << FRAC_BITS));
   localparam logic signed [32:0] EDGE_MAX = 33'sd2147483647;
   localparam logic signed [33:0] WMAX34   = 34'(WEIGHT_MAX);
   localparam logic signed [64:0] OUT_MAX  = 65'sd2147483647;
   localparam logic signed [64:0] OUT_MIN  = -65'sd2147483648;

   typedef enum logic [16:0] {
      ST_IDLE     = 17'h00001,
      ST_TCORNER  = 17'h00002,
      ST_TLATCH   = 17'h00004,
      ST_TPOINT   = 17'h00008,
      ST_EDGE     = 17'h00010,
      ST_MUL      = 17'h00020,
      ST_CHECK    = 17'h00040,
      ST_DIVW     = 17'h00080,
      ST_WAITW    = 17'h00100,
      ST_DIVV     = 17'h00200,
      ST_WAITV    = 17'h00400,
      ST_WEIGHT   = 17'h00800,
      ST_ECORNER  = 17'h01000,
      ST_ELATCH   = 17'h02000,
      ST_EPOINT   = 17'h04000,
      ST_BLEND    = 17'h08000,
      ST_RESULT   = 17'h10000
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic [10:0]        tcount_ff;
   logic [TCW-1:0]     ntri_ff, ntri_in;
   logic [TCW-1:0]     tri_ff, tri_in;
   logic [TCW-1:0]     etri_ff, etri_in;
   logic signed [31:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [32:0]        cidx_ff, cidx_in;
   logic signed [31:0] ptx_ff [3];
   logic signed [31:0] pty_ff [3];
   logic signed [31:0] ptx_in [3];
   logic signed [31:0] pty_in [3];
   logic               pok_ff;
   logic signed [31:0] e0x_ff, e0y_ff, e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic signed [31:0] e0x_in, e0y_in, e1x_in, e1y_in, e2x_in, e2y_in;
   logic signed [63:0] prod_ff;
   logic signed [63:0] det_ff, det_in, nw_ff, nw_in, nv_ff, nv_in;
   weight_type         w_ff, w_in, v_ff, v_in;
   weight_type         bw_ff [3];
   weight_type         bw_in [3];
   logic [31:0]        best_ff, best_in;
   logic               inside_ff, inside_in;
   logic signed [64:0] accx_ff, accx_in, accy_ff, accy_in;
   logic               rvalid_ff, rvalid_in;
   logic signed [31:0] ru_ff, ru_in, rv_ff, rv_in;
   logic               rin_ff, rin_in;
   logic [9:0]         rtri_ff, rtri_in;

   logic               req_acc;
   logic               slot_pt_ok, slot_tri_ok;
   logic [31:0]        slot_ext;
   logic [10:0]        pidx;
   logic [31:0]        pidx_ext;
   logic               pidx_ok;
   logic [63:0]        img_rd, tex_rd;
   logic [32:0]        icor_rd, tcor_rd;
   logic [31:0]        tri_ext, etri_ext;
   logic [31:0]        nq;
   logic signed [31:0] mul_a, mul_b;
   logic               div_start;
   logic signed [63:0] div_num;
   div_res_type        div_res;
   logic signed [31:0] rdx, rdy;
   logic signed [33:0] u_raw;
   weight_type         u_w;
   logic signed [32:0] hd [3];
   logic [31:0]        hmag [3];
   logic [31:0]        score;
   logic               inside_now;
   logic [TCW:0]       tri_next;
   logic signed [64:0] shx, shy;
   logic signed [31:0] outx, outy;

   // saturated edge component
   function automatic logic signed [31:0] edge_sat(input logic signed [31:0] hi,
                                                   input logic signed [31:0] lo);
      logic signed [32:0] d;
      d = 33'(hi) - 33'(lo);
      if (d > EDGE_MAX) begin
         return EDGE_MAX[31:0];
      end else if (d < -EDGE_MAX) begin
         return -EDGE_MAX[31:0];
      end
      return d[31:0];
   endfunction

   // output saturation after the fraction shift
   function automatic logic signed [31:0] out_sat(input logic signed [64:0] s);
      if (s > OUT_MAX) begin
         return OUT_MAX[31:0];
      end else if (s < OUT_MIN) begin
         return OUT_MIN[31:0];
      end
      return s[31:0];
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // write address checks
   assign slot_ext    = {21'd0, req_slot};
   assign slot_pt_ok  = (slot_ext < 32'(MAX_POINTS));
   assign slot_tri_ok = (slot_ext < 32'(MAX_TRIANGLES));
   assign tri_ext     = 32'(tri_ff);
   assign etri_ext    = 32'(etri_ff);
   assign nq          = ({21'd0, tcount_ff} > 32'(MAX_TRIANGLES)) ? 32'(MAX_TRIANGLES)
                                                               : {21'd0, tcount_ff};

   // point index for the corner read of this step, out of range reads as zero
   always_comb begin
      case (step_ff)
         3'd0:    pidx = cidx_ff[32:22];
         3'd1:    pidx = cidx_ff[21:11];
         default: pidx = cidx_ff[10:0];
      endcase
   end
   assign pidx_ext = {21'd0, pidx};
   assign pidx_ok  = (pidx_ext < 32'(MAX_POINTS));

   // stores
   mbuv_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_img_pt (
      .clock   (clock),
      .wr_en   (req_acc && (req_op == OP_IMG_POINT) && slot_pt_ok),
      .wr_addr (slot_ext[PAW-1:0]),
      .wr_data ({req_x_value, req_y_value}),
      .rd_addr (pidx_ext[PAW-1:0]),
      .rd_data (img_rd)
   );

   mbuv_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_tex_pt (
      .clock   (clock),
      .wr_en   (req_acc && (req_op == OP_TEX_POINT) && slot_pt_ok),
      .wr_addr (slot_ext[PAW-1:0]),
      .wr_data ({req_x_value, req_y_value}),
      .rd_addr (pidx_ext[PAW-1:0]),
      .rd_data (tex_rd)
   );

   mbuv_ram #(.WIDTH(33), .DEPTH(MAX_TRIANGLES)) u_img_cor (
      .clock   (clock),
      .wr_en   (req_acc && (req_op == OP_TRIANGLE) && slot_tri_ok),
      .wr_addr (slot_ext[TAW-1:0]),
      .wr_data ({req_corner_a, req_corner_b, req_corner_c}),
      .rd_addr (tri_ext[TAW-1:0]),
      .rd_data (icor_rd)
   );

   mbuv_ram #(.WIDTH(33), .DEPTH(MAX_TRIANGLES)) u_tex_cor (
      .clock   (clock),
      .wr_en   (req_acc && (req_op == OP_TRIANGLE) && slot_tri_ok),
      .wr_addr (slot_ext[TAW-1:0]),
      .wr_data ({req_tex_a, req_tex_b, req_tex_c}),
      .rd_addr (etri_ext[TAW-1:0]),
      .rd_data (tcor_rd)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         case (step_ff)
            3'd0:    begin mul_a = e0x_ff; mul_b = e1y_ff; end
            3'd1:    begin mul_a = e0y_ff; mul_b = e1x_ff; end
            3'd2:    begin mul_a = e2x_ff; mul_b = e1y_ff; end
            3'd3:    begin mul_a = e2y_ff; mul_b = e1x_ff; end
            3'd4:    begin mul_a = e0x_ff; mul_b = e2y_ff; end
            3'd5:    begin mul_a = e0y_ff; mul_b = e2x_ff; end
            default: begin mul_a = '0;     mul_b = '0;     end
         endcase
      end else begin
         case (step_ff)
            3'd0:    begin mul_a = bw_ff[0]; mul_b = ptx_ff[0]; end
            3'd1:    begin mul_a = bw_ff[1]; mul_b = ptx_ff[1]; end
            3'd2:    begin mul_a = bw_ff[2]; mul_b = ptx_ff[2]; end
            3'd3:    begin mul_a = bw_ff[0]; mul_b = pty_ff[0]; end
            3'd4:    begin mul_a = bw_ff[1]; mul_b = pty_ff[1]; end
            3'd5:    begin mul_a = bw_ff[2]; mul_b = pty_ff[2]; end
            default: begin mul_a = '0;       mul_b = '0;       end
         endcase
      end
   end

   // shared divider
   assign div_start = (state_ff == ST_DIVW) || (state_ff == ST_DIVV);
   assign div_num   = (state_ff == ST_DIVW) ? nw_ff : nv_ff;

   mbuv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (det_ff),
      .res   (div_res)
   );

   // point data of the read issued last cycle
   assign rdx = pok_ff ? $signed((state_ff == ST_EPOINT) ? tex_rd[63:32] : img_rd[63:32])
                       : '0;
   assign rdy = pok_ff ? $signed((state_ff == ST_EPOINT) ? tex_rd[31:0] : img_rd[31:0])
                       : '0;

   // third weight, inside test and fallback score
   assign u_raw      = 34'(ONE_Q) - 34'(v_ff) - 34'(w_ff);
   assign u_w        = (u_raw > WMAX34) ? WEIGHT_MAX :
                       ((u_raw < -WMAX34) ? -WEIGHT_MAX : u_raw[31:0]);
   assign inside_now = !u_w[31] && !v_ff[31] && !w_ff[31];
   assign hd[0]      = 33'(HALF_Q) - 33'(u_w);
   assign hd[1]      = 33'(HALF_Q) - 33'(v_ff);
   assign hd[2]      = 33'(HALF_Q) - 33'(w_ff);
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hmag[k] = hd[k][32] ? 32'(-hd[k]) : hd[k][31:0];
      end
   end
   assign score    = (hmag[0] > hmag[1]) ? ((hmag[0] > hmag[2]) ? hmag[0] : hmag[2])
                                         : ((hmag[1] > hmag[2]) ? hmag[1] : hmag[2]);
   assign tri_next = {1'b0, tri_ff} + 1'b1;

   // final shift and saturation
   assign shx  = accx_ff >>> FRAC_BITS;
   assign shy  = accy_ff >>> FRAC_BITS;
   assign outx = out_sat(shx);
   assign outy = out_sat(shy);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      ntri_in   = ntri_ff;
      tri_in    = tri_ff;
      etri_in   = etri_ff;
      qx_in     = qx_ff;
      qy_in     = qy_ff;
      cidx_in   = cidx_ff;
      ptx_in    = ptx_ff;
      pty_in    = pty_ff;
      e0x_in    = e0x_ff;
      e0y_in    = e0y_ff;
      e1x_in    = e1x_ff;
      e1y_in    = e1y_ff;
      e2x_in    = e2x_ff;
      e2y_in    = e2y_ff;
      det_in    = det_ff;
      nw_in     = nw_ff;
      nv_in     = nv_ff;
      w_in      = w_ff;
      v_in      = v_ff;
      bw_in     = bw_ff;
      best_in   = best_ff;
      inside_in = inside_ff;
      accx_in   = accx_ff;
      accy_in   = accy_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      ru_in     = ru_ff;
      rv_in     = rv_ff;
      rin_in    = rin_ff;
      rtri_in   = rtri_ff;
      case (state_ff)
         ST_IDLE: begin
            // start a query, writes finish in this cycle
            if (req_acc && (req_op == OP_QUERY)) begin
               qx_in     = req_x_value;
               qy_in     = req_y_value;
               ntri_in   = nq[TCW-1:0];
               tri_in    = '0;
               etri_in   = '0;
               best_in   = '1;
               bw_in[0]  = INIT_W;
               bw_in[1]  = INIT_W;
               bw_in[2]  = INIT_W;
               inside_in = 1'b0;
               state_in  = (nq == 32'd0) ? ST_ECORNER : ST_TCORNER;
            end
         end
         ST_TCORNER: begin
            state_in = ST_TLATCH;
         end
         ST_TLATCH: begin
            cidx_in  = icor_rd;
            step_in  = '0;
            state_in = ST_TPOINT;
         end
         ST_TPOINT: begin
            // three image point reads, the data of each read taken in the next step
            if (step_ff != 3'd0) begin
               ptx_in[2'(step_ff - 3'd1)] = rdx;
               pty_in[2'(step_ff - 3'd1)] = rdy;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            e0x_in   = edge_sat(ptx_ff[2], ptx_ff[0]);
            e0y_in   = edge_sat(pty_ff[2], pty_ff[0]);
            e1x_in   = edge_sat(ptx_ff[1], ptx_ff[0]);
            e1y_in   = edge_sat(pty_ff[1], pty_ff[0]);
            e2x_in   = edge_sat(qx_ff, ptx_ff[0]);
            e2y_in   = edge_sat(qy_ff, pty_ff[0]);
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // cross products, one product per cycle
            case (step_ff)
               3'd1:    det_in = prod_ff;
               3'd2:    det_in = det_ff - prod_ff;
               3'd3:    nw_in  = prod_ff;
               3'd4:    nw_in  = nw_ff - prod_ff;
               3'd5:    nv_in  = prod_ff;
               3'd6:    nv_in  = nv_ff - prod_ff;
               default: det_in = det_ff;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // degenerate triangle is skipped
            if (det_ff == 64'd0) begin
               if (tri_next >= {1'b0, ntri_ff}) begin
                  state_in = ST_ECORNER;
               end else begin
                  tri_in   = tri_next[TCW-1:0];
                  state_in = ST_TCORNER;
               end
            end else begin
               state_in = ST_DIVW;
            end
         end
         ST_DIVW: begin
            state_in = ST_WAITW;
         end
         ST_WAITW: begin
            if (div_res.done) begin
               w_in     = div_res.quo;
               state_in = ST_DIVV;
            end
         end
         ST_DIVV: begin
            state_in = ST_WAITV;
         end
         ST_WAITV: begin
            if (div_res.done) begin
               v_in     = div_res.quo;
               state_in = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            if (inside_now) begin
               bw_in[0]  = u_w;
               bw_in[1]  = v_ff;
               bw_in[2]  = w_ff;
               etri_in   = tri_ff;
               inside_in = 1'b1;
               state_in  = ST_ECORNER;
            end else begin
               // keep the first triangle with the least score
               if (score < best_ff) begin
                  best_in  = score;
                  bw_in[0] = u_w;
                  bw_in[1] = v_ff;
                  bw_in[2] = w_ff;
                  etri_in  = tri_ff;
               end
               if (tri_next >= {1'b0, ntri_ff}) begin
                  state_in = ST_ECORNER;
               end else begin
                  tri_in   = tri_next[TCW-1:0];
                  state_in = ST_TCORNER;
               end
            end
         end
         ST_ECORNER: begin
            state_in = ST_ELATCH;
         end
         ST_ELATCH: begin
            cidx_in  = tcor_rd;
            step_in  = '0;
            state_in = ST_EPOINT;
         end
         ST_EPOINT: begin
            // three texture point reads
            if (step_ff != 3'd0) begin
               ptx_in[2'(step_ff - 3'd1)] = rdx;
               pty_in[2'(step_ff - 3'd1)] = rdy;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               step_in  = '0;
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            // weighted sums, x then y
            case (step_ff)
               3'd1:    accx_in = 65'(prod_ff);
               3'd2:    accx_in = accx_ff + 65'(prod_ff);
               3'd3:    accx_in = accx_ff + 65'(prod_ff);
               3'd4:    accy_in = 65'(prod_ff);
               3'd5:    accy_in = accy_ff + 65'(prod_ff);
               3'd6:    accy_in = accy_ff + 65'(prod_ff);
               default: accx_in = accx_ff;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // wait for the output register to be free
            if (!rvalid_ff || !rsp_stall) begin
               rvalid_in = 1'b1;
               ru_in     = outx;
               rv_in     = outy;
               rin_in    = inside_ff;
               rtri_in   = etri_ext[9:0];
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
         tcount_ff <= '0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         step_ff   <= step_in;
         if (csr_valid && csr_ready) begin
            tcount_ff <= csr_wdata;
         end
      end
      ntri_ff   <= ntri_in;
      tri_ff    <= tri_in;
      etri_ff   <= etri_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      cidx_ff   <= cidx_in;
      ptx_ff    <= ptx_in;
      pty_ff    <= pty_in;
      pok_ff    <= pidx_ok;
      e0x_ff    <= e0x_in;
      e0y_ff    <= e0y_in;
      e1x_ff    <= e1x_in;
      e1y_ff    <= e1y_in;
      e2x_ff    <= e2x_in;
      e2y_ff    <= e2y_in;
      prod_ff   <= mul_a * mul_b;
      det_ff    <= det_in;
      nw_ff     <= nw_in;
      nv_ff     <= nv_in;
      w_ff      <= w_in;
      v_ff      <= v_in;
      bw_ff     <= bw_in;
      best_ff   <= best_in;
      inside_ff <= inside_in;
      accx_ff   <= accx_in;
      accy_ff   <= accy_in;
      ru_ff     <= ru_in;
      rv_ff     <= rv_in;
      rin_ff    <= rin_in;
      rtri_ff   <= rtri_in;
   end

   assign rsp_valid          = rvalid_ff;
   assign rsp_u_coord        = ru_ff;
   assign rsp_v_coord        = rv_ff;
   assign rsp_inside_res     = rin_ff;
   assign rsp_triangle_found = rtri_ff;

endmodule
`default_nettype wire
